FILE: sv/waypoint_trajectory_generator_macros.svh
// Assertion helpers for the waypoint trajectory generator.
`ifndef WAYPOINT_TRAJECTORY_GENERATOR_MACROS_SVH
`define WAYPOINT_TRAJECTORY_GENERATOR_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define WTG_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("wtg assertion failed");

// Next-cycle implication, sampled on clock, off during reset.
`define WTG_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("wtg assertion failed");

`endif

FILE: sv/wtg_pkg.sv
`default_nettype none
package wtg_pkg;

   localparam int MAX_POINTS_DEFAULT   = 8;
   localparam int CORDIC_STEPS_DEFAULT = 16;

   localparam int TIME_W     = 24;
   localparam int POS_W      = 16;
   localparam int HEAD_W     = 16;
   localparam int PTS_W      = 4;
   localparam int CORD_W     = 34;
   localparam int MUL_W      = 52;
   localparam int QUO_W      = 17;
   localparam int REM_W      = 25;
   localparam int STEP_W     = 5;

   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;
   localparam logic MODE_LINE  = 1'b1;

   localparam logic [PTS_W-1:0] PTS_RESET = 4'd7;

   localparam logic [31:0] PI_Q30   = 32'd3373259426;
   localparam logic [15:0] PI_HI    = 16'(PI_Q30 >> 16);
   localparam logic [15:0] PI_LO    = PI_Q30[15:0];
   localparam logic [29:0] GAIN_Q30 = 30'd652032874;
   localparam logic [14:0] GAIN_HI  = 15'(GAIN_Q30 >> 15);
   localparam logic [14:0] GAIN_LO  = GAIN_Q30[14:0];

   localparam logic signed [MUL_W-1:0] HALF_PI_Q30   = 52'sd1686629713;
   localparam logic signed [CORD_W-1:0] HEADING_LIMIT = 34'sd25736;

   localparam logic [STEP_W-1:0] DIV_LAST = 5'd16;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_LAST_RD,
      ST_LAST_CHK,
      ST_FIRST_RD,
      ST_FIRST_CHK,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_DIV,
      ST_LINE_X,
      ST_LINE_Y,
      ST_LINE_END,
      ST_ZHI,
      ST_ZLO,
      ST_ZEND,
      ST_ROT,
      ST_GXH,
      ST_GXL,
      ST_GYH,
      ST_GYL,
      ST_GEND,
      ST_CIRC_END,
      ST_HEAD,
      ST_VEC,
      ST_HEAD_END,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [TIME_W-1:0] tm;
      logic [POS_W-1:0]  x;
      logic [POS_W-1:0]  y;
      logic              mode;
   } entry_type;

   function automatic logic [29:0] atan_q30(input logic [STEP_W-1:0] i);
      logic [29:0] r;
      case (i)
         5'd0:  r = 30'd843314856;
         5'd1:  r = 30'd497837829;
         5'd2:  r = 30'd263043836;
         5'd3:  r = 30'd133525158;
         5'd4:  r = 30'd67021686;
         5'd5:  r = 30'd33543515;
         5'd6:  r = 30'd16775850;
         5'd7:  r = 30'd8388437;
         5'd8:  r = 30'd4194282;
         5'd9:  r = 30'd2097149;
         5'd10: r = 30'd1048575;
         5'd11: r = 30'd524287;
         5'd12: r = 30'd262143;
         5'd13: r = 30'd131071;
         5'd14: r = 30'd65535;
         5'd15: r = 30'd32767;
         5'd16: r = 30'd16383;
         5'd17: r = 30'd8191;
         5'd18: r = 30'd4095;
         5'd19: r = 30'd2047;
         5'd20: r = 30'd1023;
         5'd21: r = 30'd511;
         5'd22: r = 30'd255;
         5'd23: r = 30'd127;
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic [POS_W-1:0] sat16(input logic signed [MUL_W-1:0] v);
      logic [POS_W-1:0] r;
      if (v > 52'sd32767) begin
         r = 16'h7FFF;
      end else if (v < -52'sd32768) begin
         r = 16'h8000;
      end else begin
         r = v[POS_W-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: sv/waypoint_trajectory_generator.sv
// The time from accept to result is set by the table scan, which reads and then checks
// each entry, by the 17-step divider and by the CORDIC iterations of one shared rotator;
// a sample time past the last entry skips the scan and the divider. One item at a time.
// Reset: synchronous, active high; points_in_use returns to 7, last pose to zero;
// the waypoint table is undefined until written.
`default_nettype none
`include "waypoint_trajectory_generator_macros.svh"
module waypoint_trajectory_generator
   import wtg_pkg::*;
#(
   parameter int MAX_POINTS   = MAX_POINTS_DEFAULT,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic                 req_type,
   input  wire logic [2:0]           req_point_index,
   input  wire logic [TIME_W-1:0]    req_point_time,
   input  wire logic signed [15:0]   req_point_x,
   input  wire logic signed [15:0]   req_point_y,
   input  wire logic                 req_point_mode,
   input  wire logic [TIME_W-1:0]    req_sample_time,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic signed [15:0]        rsp_pose_x,
   output logic signed [15:0]        rsp_pose_y,
   output logic signed [15:0]        rsp_pose_heading,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [PTS_W-1:0]     csr_points_in_use
);

   localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W = $clog2(MAX_POINTS + 1);

   state_type state_ff, state_in;

   logic [PTS_W-1:0]        pts_ff, pts_in;
   logic [TIME_W-1:0]       t_ff, t_in;
   logic [CNT_W-1:0]        n_ff, n_in, k_ff, k_in, n_calc;
   logic [IDX_W-1:0]        rd_idx_ff, rd_idx_in, wr_idx;
   entry_type               rd_ff, first_ff, first_in, prev_ff, prev_in, cur_ff, cur_in;
   entry_type               wr_entry;
   logic [REM_W-1:0]        rem_ff, rem_in, rem_try;
   logic [TIME_W-1:0]       span_ff, span_in;
   logic [QUO_W-1:0]        quo_ff, quo_in;
   logic [STEP_W-1:0]       cnt_ff, cnt_in;
   logic signed [MUL_W-1:0] mul_ff, mul_in, acc_ff, acc_in;
   logic signed [CORD_W-1:0] cx_ff, cx_in, cy_ff, cy_in, z_ff, z_in;
   logic [POS_W-1:0]        px_ff, px_in, py_ff, py_in;
   logic [POS_W-1:0]        last_x_ff, last_x_in, last_y_ff, last_y_in;
   logic [HEAD_W-1:0]       last_hd_ff, last_hd_in;

   logic signed [CORD_W-1:0] mul_a;
   logic [QUO_W-1:0]         mul_b;

   logic [31:0]              idx_wide;
   logic                     mem_we;
   entry_type                table_mem [MAX_POINTS];

   logic                     after_last, seg_hit, scan_end, div_done, cord_done, unmoved;
   logic [16:0]              ddx, ddy, hdx, hdy, sdx, sdy;
   logic signed [MUL_W-1:0]  rnd, mshr15, mshr16, gsum, zsum, csx, csy, shx, shy;
   logic signed [CORD_W-1:0] sh_x, sh_y, at_s, hx, hy, hz, hr;
   logic                     cord_dir;

   // configuration
   assign csr_ready = 1'b1;
   assign pts_in    = csr_valid ? csr_points_in_use : pts_ff;

   always_comb begin
      if (32'(pts_ff) < 32'd2) begin
         n_calc = CNT_W'(2);
      end else if (32'(pts_ff) > 32'(MAX_POINTS)) begin
         n_calc = CNT_W'(MAX_POINTS);
      end else begin
         n_calc = CNT_W'(pts_ff);
      end
   end

   // waypoint table
   assign idx_wide = 32'(req_point_index);
   assign wr_idx   = idx_wide[IDX_W-1:0];
   assign wr_entry = '{tm: req_point_time, x: req_point_x, y: req_point_y,
                       mode: req_point_mode};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[wr_idx] <= wr_entry;
      end
      rd_ff <= table_mem[rd_idx_ff];
   end

   // conditions
   assign after_last = t_ff > rd_ff.tm;
   assign seg_hit    = (prev_ff.tm <= t_ff) && (t_ff <= rd_ff.tm);
   assign scan_end   = k_ff == (n_ff - CNT_W'(1));
   assign div_done   = (span_ff == '0) || (cnt_ff == DIV_LAST);
   assign cord_done  = cnt_ff == STEP_W'(CORDIC_STEPS - 1);
   assign unmoved    = (px_ff == last_x_ff) && (py_ff == last_y_ff);

   assign ddx = {cur_ff.x[15], cur_ff.x} - {prev_ff.x[15], prev_ff.x};
   assign ddy = {cur_ff.y[15], cur_ff.y} - {prev_ff.y[15], prev_ff.y};
   assign sdx = {cur_ff.x[15], cur_ff.x} + {prev_ff.x[15], prev_ff.x};
   assign sdy = {cur_ff.y[15], cur_ff.y} + {prev_ff.y[15], prev_ff.y};
   assign hdx = {px_ff[15], px_ff} - {last_x_ff[15], last_x_ff};
   assign hdy = {py_ff[15], py_ff} - {last_y_ff[15], last_y_ff};
   assign hx  = {{3{hdx[16]}}, hdx, 14'b0};
   assign hy  = {{3{hdy[16]}}, hdy, 14'b0};

   // shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_LINE_X: begin
            mul_a = {{17{ddx[16]}}, ddx};
            mul_b = quo_ff;
         end
         ST_LINE_Y: begin
            mul_a = {{17{ddy[16]}}, ddy};
            mul_b = quo_ff;
         end
         ST_ZHI: begin
            mul_a = CORD_W'(quo_ff);
            mul_b = {1'b0, PI_HI};
         end
         ST_ZLO: begin
            mul_a = CORD_W'(quo_ff);
            mul_b = {1'b0, PI_LO};
         end
         ST_GXH: begin
            mul_a = cx_ff;
            mul_b = {2'b0, GAIN_HI};
         end
         ST_GXL: begin
            mul_a = cx_ff;
            mul_b = {2'b0, GAIN_LO};
         end
         ST_GYH: begin
            mul_a = cy_ff;
            mul_b = {2'b0, GAIN_HI};
         end
         ST_GYL: begin
            mul_a = cy_ff;
            mul_b = {2'b0, GAIN_LO};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_in = MUL_W'(mul_a * $signed({1'b0, mul_b}));

   // shared CORDIC step: rotation steers by z, vectoring by y
   assign cord_dir = (state_ff == ST_VEC) ? cy_ff[CORD_W-1] : !z_ff[CORD_W-1];
   assign sh_x     = cy_ff >>> cnt_ff;
   assign sh_y     = cx_ff >>> cnt_ff;
   assign at_s     = {4'b0, atan_q30(cnt_ff)};

   // rounding and scaling terms
   always_comb begin
      rnd    = (mul_ff + 52'sd32768) >>> 16;
      mshr15 = mul_ff >>> 15;
      mshr16 = mul_ff >>> 16;
      gsum   = (acc_ff + mshr15) >>> 15;
      zsum   = acc_ff + mshr16 - HALF_PI_Q30;
      csx    = {{22{sdx[16]}}, sdx, 13'b0} + {{18{cx_ff[CORD_W-1]}}, cx_ff} + 52'sd8192;
      csy    = {{22{sdy[16]}}, sdy, 13'b0} + {{18{cy_ff[CORD_W-1]}}, cy_ff} + 52'sd8192;
      shx    = csx >>> 14;
      shy    = csy >>> 14;
      hz     = z_ff + 34'sd65536;
      hr     = hz >>> 17;
   end

   always_comb begin
      rem_try = (cnt_ff == '0) ? rem_ff : {rem_ff[REM_W-2:0], 1'b0};
   end

   // datapath next values
   always_comb begin
      t_in       = t_ff;
      n_in       = n_ff;
      k_in       = k_ff;
      rd_idx_in  = rd_idx_ff;
      first_in   = first_ff;
      prev_in    = prev_ff;
      cur_in     = cur_ff;
      rem_in     = rem_ff;
      span_in    = span_ff;
      quo_in     = quo_ff;
      cnt_in     = cnt_ff;
      acc_in     = acc_ff;
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      z_in       = z_ff;
      px_in      = px_ff;
      py_in      = py_ff;
      last_x_in  = last_x_ff;
      last_y_in  = last_y_ff;
      last_hd_in = last_hd_ff;
      unique case (state_ff)
         ST_IDLE: begin
            t_in      = req_sample_time;
            n_in      = n_calc;
            rd_idx_in = IDX_W'(n_calc - CNT_W'(1));
         end
         ST_LAST_CHK: begin
            px_in     = rd_ff.x;
            py_in     = rd_ff.y;
            rd_idx_in = '0;
         end
         ST_FIRST_CHK: begin
            first_in  = rd_ff;
            prev_in   = rd_ff;
            k_in      = CNT_W'(1);
            rd_idx_in = IDX_W'(1);
         end
         ST_SCAN_CHK: begin
            cur_in  = rd_ff;
            rem_in  = REM_W'(t_ff - prev_ff.tm);
            span_in = rd_ff.tm - prev_ff.tm;
            quo_in  = '0;
            cnt_in  = '0;
            px_in   = first_ff.x;
            py_in   = first_ff.y;
            if (!seg_hit) begin
               prev_in   = rd_ff;
               k_in      = k_ff + CNT_W'(1);
               rd_idx_in = IDX_W'(k_ff + CNT_W'(1));
            end
         end
         ST_DIV: begin
            if (span_ff == '0) begin
               quo_in = 17'h10000;
            end else if (rem_try >= {1'b0, span_ff}) begin
               rem_in = rem_try - {1'b0, span_ff};
               quo_in = {quo_ff[QUO_W-2:0], 1'b1};
            end else begin
               rem_in = rem_try;
               quo_in = {quo_ff[QUO_W-2:0], 1'b0};
            end
            cnt_in = div_done ? '0 : cnt_ff + STEP_W'(1);
         end
         ST_LINE_Y: begin
            px_in = sat16(rnd + {{36{prev_ff.x[15]}}, prev_ff.x});
         end
         ST_LINE_END: begin
            py_in = sat16(rnd + {{36{prev_ff.y[15]}}, prev_ff.y});
         end
         ST_ZHI: begin
            cx_in = {{4{ddy[16]}}, ddy, 13'b0};
            cy_in = -{{4{ddx[16]}}, ddx, 13'b0};
         end
         ST_ZLO: begin
            acc_in = mul_ff;
         end
         ST_ZEND: begin
            z_in   = CORD_W'(zsum);
            cnt_in = '0;
         end
         ST_ROT, ST_VEC: begin
            if (cord_dir) begin
               cx_in = cx_ff - sh_x;
               cy_in = cy_ff + sh_y;
               z_in  = z_ff - at_s;
            end else begin
               cx_in = cx_ff + sh_x;
               cy_in = cy_ff - sh_y;
               z_in  = z_ff + at_s;
            end
            cnt_in = cord_done ? '0 : cnt_ff + STEP_W'(1);
         end
         ST_GXL: begin
            acc_in = mul_ff;
         end
         ST_GYH: begin
            cx_in = CORD_W'(gsum);
         end
         ST_GYL: begin
            acc_in = mul_ff;
         end
         ST_GEND: begin
            cy_in = CORD_W'(gsum);
         end
         ST_CIRC_END: begin
            px_in = sat16(shx);
            py_in = sat16(shy);
         end
         ST_HEAD: begin
            cnt_in = '0;
            if (hx[CORD_W-1]) begin
               if (!hy[CORD_W-1]) begin
                  cx_in = hy;
                  cy_in = -hx;
                  z_in  = CORD_W'(HALF_PI_Q30);
               end else begin
                  cx_in = -hy;
                  cy_in = hx;
                  z_in  = -CORD_W'(HALF_PI_Q30);
               end
            end else begin
               cx_in = hx;
               cy_in = hy;
               z_in  = '0;
            end
         end
         ST_HEAD_END: begin
            last_x_in = px_ff;
            last_y_in = py_ff;
            if (hr > HEADING_LIMIT) begin
               last_hd_in = HEAD_W'(HEADING_LIMIT);
            end else if (hr < -HEADING_LIMIT) begin
               last_hd_in = HEAD_W'(-HEADING_LIMIT);
            end else begin
               last_hd_in = hr[HEAD_W-1:0];
            end
         end
         default: begin
            t_in = t_ff;
         end
      endcase
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (req_valid && req_type == REQ_SAMPLE) state_in = ST_LAST_RD;
         ST_LAST_RD:   state_in = ST_LAST_CHK;
         ST_LAST_CHK:  state_in = after_last ? ST_HEAD : ST_FIRST_RD;
         ST_FIRST_RD:  state_in = ST_FIRST_CHK;
         ST_FIRST_CHK: state_in = ST_SCAN_RD;
         ST_SCAN_RD:   state_in = ST_SCAN_CHK;
         ST_SCAN_CHK: begin
            if (seg_hit) begin
               state_in = ST_DIV;
            end else if (scan_end) begin
               state_in = ST_HEAD;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_DIV: begin
            if (div_done) state_in = (cur_ff.mode == MODE_LINE) ? ST_LINE_X : ST_ZHI;
         end
         ST_LINE_X:    state_in = ST_LINE_Y;
         ST_LINE_Y:    state_in = ST_LINE_END;
         ST_LINE_END:  state_in = ST_HEAD;
         ST_ZHI:       state_in = ST_ZLO;
         ST_ZLO:       state_in = ST_ZEND;
         ST_ZEND:      state_in = ST_ROT;
         ST_ROT:       if (cord_done) state_in = ST_GXH;
         ST_GXH:       state_in = ST_GXL;
         ST_GXL:       state_in = ST_GYH;
         ST_GYH:       state_in = ST_GYL;
         ST_GYL:       state_in = ST_GEND;
         ST_GEND:      state_in = ST_CIRC_END;
         ST_CIRC_END:  state_in = ST_HEAD;
         ST_HEAD:      state_in = unmoved ? ST_OUT : ST_VEC;
         ST_VEC:       if (cord_done) state_in = ST_HEAD_END;
         ST_HEAD_END:  state_in = ST_OUT;
         ST_OUT:       if (!rsp_stall) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      mem_we    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            mem_we    = req_valid && (req_type == REQ_LOAD)
                        && (idx_wide < 32'(MAX_POINTS));
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign rsp_pose_x       = last_x_ff;
   assign rsp_pose_y       = last_y_ff;
   assign rsp_pose_heading = last_hd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pts_ff     <= PTS_RESET;
         last_x_ff  <= '0;
         last_y_ff  <= '0;
         last_hd_ff <= '0;
      end else begin
         state_ff   <= state_in;
         pts_ff     <= pts_in;
         last_x_ff  <= last_x_in;
         last_y_ff  <= last_y_in;
         last_hd_ff <= last_hd_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff      <= t_in;
      n_ff      <= n_in;
      k_ff      <= k_in;
      rd_idx_ff <= rd_idx_in;
      first_ff  <= first_in;
      prev_ff   <= prev_in;
      cur_ff    <= cur_in;
      rem_ff    <= rem_in;
      span_ff   <= span_in;
      quo_ff    <= quo_in;
      cnt_ff    <= cnt_in;
      mul_ff    <= mul_in;
      acc_ff    <= acc_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      z_ff      <= z_in;
      px_ff     <= px_in;
      py_ff     <= py_in;
   end

   `WTG_ASSERT_SAME(a_rsp_holds_req, rsp_valid, req_stall)
   `WTG_ASSERT_NEXT(a_one_rsp, rsp_valid && !rsp_stall, !rsp_valid)
   `WTG_ASSERT_NEXT(a_sample_busy, req_valid && !req_stall && req_type == REQ_SAMPLE, req_stall)
   `WTG_ASSERT_NEXT(a_load_silent, req_valid && !req_stall && req_type == REQ_LOAD, !rsp_valid)

endmodule
`default_nettype wire
